// File: sv/point_triangle_feature_classifier_macros.svh
// ----------------------------------------------------------------------------
// Point/triangle feature classifier: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POINT_TRIANGLE_FEATURE_CLASSIFIER_MACROS_SVH
`define POINT_TRIANGLE_FEATURE_CLASSIFIER_MACROS_SVH

// cons must hold in the cycle after ante
`define PTFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptfc assertion failed");

// sig must keep its value into the cycle after cond
`define PTFC_ASSERT_HOLD(label, cond, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error("ptfc hold assertion failed");

`endif

// File: sv/ptfc_pkg.sv
// ----------------------------------------------------------------------------
// ptfc_pkg
// Shared types and constants of the point/triangle feature classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptfc_pkg;

  localparam int unsigned NumCoords  = 12;
  localparam int unsigned TolWidth   = 32;
  localparam int unsigned KindWidth  = 2;
  localparam int unsigned OutTdataW  = 8;

  typedef enum logic [KindWidth-1:0] {
    KindVertex = 2'd0,
    KindEdge   = 2'd1,
    KindFace   = 2'd2
  } feature_kind_e;

endpackage

// File: sv/ptfc_front.sv
// ----------------------------------------------------------------------------
// ptfc_front
// Stages one to three: coordinate differences, products, vertex distance
// test, squared edge lengths and cross product magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptfc_front #(
  parameter int unsigned W = 16
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [ptfc_pkg::NumCoords-1:0][W-1:0] coord_i,
  input  logic [ptfc_pkg::TolWidth-1:0]         tol_i,
  output logic [2:0]                            vhit_o,
  output logic [2:0][2*W+1:0]                   dsq_o,
  output logic [2:0][2:0][2*W+1:0]              cabs_o
);

  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned VW = (PW > ptfc_pkg::TolWidth) ? PW : ptfc_pkg::TolWidth;

  logic signed [DW-1:0] e_d [3][3];
  logic signed [DW-1:0] e_q [3][3];
  logic signed [DW-1:0] d_d [3][3];
  logic signed [DW-1:0] d_q [3][3];

  logic signed [PW-1:0] esq_d [3][3];
  logic signed [PW-1:0] esq_q [3][3];
  logic signed [PW-1:0] dd_d  [3][3];
  logic signed [PW-1:0] dd_q  [3][3];
  logic signed [PW-1:0] pa_d  [3][3];
  logic signed [PW-1:0] pa_q  [3][3];
  logic signed [PW-1:0] pb_d  [3][3];
  logic signed [PW-1:0] pb_q  [3][3];

  logic [2:0]                vhit_d, vhit_q;
  logic [2:0][PW-1:0]        dsq_d, dsq_q;
  logic [2:0][2:0][PW-1:0]   cabs_d, cabs_q;

  // stage 1: p - v_k and v_{k+1} - v_k
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        e_d[k][c] = {coord_i[9 + c][W-1], coord_i[9 + c]}
                  - {coord_i[k*3 + c][W-1], coord_i[k*3 + c]};
        d_d[k][c] = {coord_i[((k + 1) % 3)*3 + c][W-1], coord_i[((k + 1) % 3)*3 + c]}
                  - {coord_i[k*3 + c][W-1], coord_i[k*3 + c]};
      end
    end
  end

  // stage 2: squares and cross product terms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        esq_d[k][c] = e_q[k][c] * e_q[k][c];
        dd_d[k][c]  = d_q[k][c] * d_q[k][c];
        pa_d[k][c]  = d_q[k][(c + 1) % 3] * e_q[k][(c + 2) % 3];
        pb_d[k][c]  = d_q[k][(c + 2) % 3] * e_q[k][(c + 1) % 3];
      end
    end
  end

  // stage 3: vertex test, edge length, cross magnitude
  always_comb begin
    logic [VW-1:0]  vsum;
    logic [PW:0]    pos;
    logic [PW:0]    neg;
    for (int k = 0; k < 3; k++) begin
      vsum = VW'($unsigned(esq_q[k][0])) + VW'($unsigned(esq_q[k][1]))
           + VW'($unsigned(esq_q[k][2]));
      vhit_d[k] = (vsum < VW'(tol_i));
      dsq_d[k]  = $unsigned(dd_q[k][0]) + $unsigned(dd_q[k][1]) + $unsigned(dd_q[k][2]);
      for (int c = 0; c < 3; c++) begin
        pos = {pa_q[k][c][PW-1], pa_q[k][c]} - {pb_q[k][c][PW-1], pb_q[k][c]};
        neg = {pb_q[k][c][PW-1], pb_q[k][c]} - {pa_q[k][c][PW-1], pa_q[k][c]};
        cabs_d[k][c] = pos[PW] ? neg[PW-1:0] : pos[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q    <= e_d;
      d_q    <= d_d;
      esq_q  <= esq_d;
      dd_q   <= dd_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      vhit_q <= vhit_d;
      dsq_q  <= dsq_d;
      cabs_q <= cabs_d;
    end
  end

  assign vhit_o = vhit_q;
  assign dsq_o  = dsq_q;
  assign cabs_o = cabs_q;

endmodule

// File: sv/ptfc_edge.sv
// ----------------------------------------------------------------------------
// ptfc_edge
// Stages four and five: split squaring of cross magnitudes and tolerance
// scaling of edge lengths, then the line distance compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptfc_edge #(
  parameter int unsigned W = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ptfc_pkg::TolWidth-1:0] tol_i,
  input  logic [2:0][2*W+1:0]           dsq_i,
  input  logic [2:0][2:0][2*W+1:0]      cabs_i,
  output logic [2:0]                    edge_hit_o
);

  localparam int unsigned H  = W + 1;
  localparam int unsigned LW = 4 * H;
  localparam int unsigned RW = ptfc_pkg::TolWidth + 2 * H;
  localparam int unsigned CW = ((LW + 2) > RW) ? (LW + 2) : RW;
  localparam int unsigned TW = ptfc_pkg::TolWidth + H;

  logic [2*H-1:0] hh_d [3][3];
  logic [2*H-1:0] hh_q [3][3];
  logic [2*H-1:0] hl_d [3][3];
  logic [2*H-1:0] hl_q [3][3];
  logic [2*H-1:0] ll_d [3][3];
  logic [2*H-1:0] ll_q [3][3];
  logic [TW-1:0]  th_d [3];
  logic [TW-1:0]  th_q [3];
  logic [TW-1:0]  tl_d [3];
  logic [TW-1:0]  tl_q [3];

  logic [CW-1:0]  sq_d  [3][3];
  logic [CW-1:0]  sq_q  [3][3];
  logic [CW-1:0]  rhs_d [3];
  logic [CW-1:0]  rhs_q [3];

  // stage 4: partial products over high and low halves
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        hh_d[k][c] = cabs_i[k][c][2*H-1:H] * cabs_i[k][c][2*H-1:H];
        hl_d[k][c] = cabs_i[k][c][2*H-1:H] * cabs_i[k][c][H-1:0];
        ll_d[k][c] = cabs_i[k][c][H-1:0]   * cabs_i[k][c][H-1:0];
      end
      th_d[k] = TW'(tol_i) * TW'(dsq_i[k][2*H-1:H]);
      tl_d[k] = TW'(tol_i) * TW'(dsq_i[k][H-1:0]);
    end
  end

  // stage 5: recombine partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        sq_d[k][c] = (CW'(hh_q[k][c]) << (2 * H)) + (CW'(hl_q[k][c]) << (H + 1))
                   + CW'(ll_q[k][c]);
      end
      rhs_d[k] = (CW'(th_q[k]) << H) + CW'(tl_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q  <= hh_d;
      hl_q  <= hl_d;
      ll_q  <= ll_d;
      th_q  <= th_d;
      tl_q  <= tl_d;
      sq_q  <= sq_d;
      rhs_q <= rhs_d;
    end
  end

  always_comb begin
    logic [CW-1:0] lhs;
    for (int k = 0; k < 3; k++) begin
      lhs = sq_q[k][0] + sq_q[k][1] + sq_q[k][2];
      edge_hit_o[k] = (lhs < rhs_q[k]);
    end
  end

endmodule

// File: sv/point_triangle_feature_classifier.sv
// ----------------------------------------------------------------------------
// point_triangle_feature_classifier
// Classifies a query point as on a vertex, on an edge line or on the face.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one triangle and query point per transaction: twelve
//   signed Q8.8 coordinates of COORD_WIDTH bits, v0 xyz, v1 xyz, v2 xyz,
//   query xyz, from the lowest bit up. m_axis returns one feature kind per
//   input transaction, in order: 0 vertex, 1 edge line, 2 face.
//   cfg_we_i/cfg_wdata_i write tol_sq (squared tolerance, Q16.16); write it
//   only while no transaction is in flight.
// Pipeline and throughput
//   Six register stages lie between the accepting edge and the result in
//   kind_q. One transaction per cycle is sustained unless the output stalls;
//   the rate is set by the single enable that moves all stages together.
// Reset
//   rst_ni clears all valid bits and sets tol_sq to 1.
// Stall
//   When m_axis_tready is low with a result waiting, every stage holds and
//   s_axis_tready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_triangle_feature_classifier_macros.svh"

module point_triangle_feature_classifier #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
  // query_x, query_y, query_z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // feature_kind
  output logic [ptfc_pkg::OutTdataW-1:0]            m_axis_tdata,
  input  logic                                      cfg_we_i,
  input  logic [ptfc_pkg::TolWidth-1:0]             cfg_wdata_i
);

  localparam int unsigned W = COORD_WIDTH;

  logic [ptfc_pkg::NumCoords-1:0][W-1:0] coord;
  logic [ptfc_pkg::TolWidth-1:0]         tol_sq_q;
  logic                                  pipe_en;
  logic [4:0]                            vld_q;
  logic                                  out_vld_q;
  logic [2:0]                            vhit3;
  logic [2:0]                            vhit4_q, vhit5_q;
  logic [2:0][2*W+1:0]                   dsq;
  logic [2:0][2:0][2*W+1:0]              cabs;
  logic [2:0]                            edge_hit;
  ptfc_pkg::feature_kind_e               kind_d, kind_q;

  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_comb begin
    for (int i = 0; i < ptfc_pkg::NumCoords; i++) begin
      coord[i] = s_axis_tdata[i*W +: W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_sq_q <= ptfc_pkg::TolWidth'(1);
    end else if (cfg_we_i) begin
      tol_sq_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q     <= {vld_q[3:0], s_axis_tvalid};
      out_vld_q <= vld_q[4];
    end
  end

  ptfc_front #(
    .W(W)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .coord_i(coord),
    .tol_i  (tol_sq_q),
    .vhit_o (vhit3),
    .dsq_o  (dsq),
    .cabs_o (cabs)
  );

  ptfc_edge #(
    .W(W)
  ) u_edge (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .tol_i     (tol_sq_q),
    .dsq_i     (dsq),
    .cabs_i    (cabs),
    .edge_hit_o(edge_hit)
  );

  always_comb begin
    if (|vhit5_q) begin
      kind_d = ptfc_pkg::KindVertex;
    end else if (|edge_hit) begin
      kind_d = ptfc_pkg::KindEdge;
    end else begin
      kind_d = ptfc_pkg::KindFace;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      vhit4_q <= vhit3;
      vhit5_q <= vhit4_q;
      kind_q  <= kind_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(ptfc_pkg::OutTdataW - ptfc_pkg::KindWidth){1'b0}}, kind_q};

  `PTFC_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0])
  `PTFC_ASSERT_HOLD(a_stall_holds, !pipe_en, {vld_q, out_vld_q})
  `PTFC_ASSERT_NEXT(a_drain_empties, m_axis_tvalid && m_axis_tready && !vld_q[4],
                    !m_axis_tvalid)

endmodule
